FILE: hdl/gpp_pkg.sv
// Package: types and constants shared by the game-port blocks.
`timescale 1ns / 1ps
package gpp_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int NUM_AXES    = 4;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_TICK   = 3'd1,
    MODE_AXIS   = 3'd2,
    MODE_BUTTON = 3'd3,
    MODE_RESET  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_HOLD   = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] OFF_BTN_LO  = 8'h61;
  localparam logic [7:0] OFF_BTN_HI  = 8'h63;
  localparam logic [7:0] OFF_PDL_LO  = 8'h64;
  localparam logic [7:0] OFF_PDL_HI  = 8'h67;
  localparam logic [7:0] OFF_TRIGGER = 8'h70;

  localparam logic [31:0] HOLD_RESET   = 32'd10230;
  localparam logic [7:0]  SCALE_RESET  = 8'd11;
  localparam logic [7:0]  OFFSET_RESET = 8'd10;
  localparam logic [7:0]  AXIS_RESET   = 8'd127;

  // One request as it sits in the input register.
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  io_offset;
    logic [7:0]  floating_bus;
    logic [47:0] now_cycle;
    logic [31:0] tick_cycles;
    logic [1:0]  stick;
    logic        axis_is_y;
    logic [7:0]  position;
    logic [1:0]  button;
    logic        pressed;
  } item_t;

endpackage

FILE: hdl/gpp_if.sv
// Interfaces: request channel and result channel.
`timescale 1ns / 1ps
interface gpp_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  io_offset;
  logic [7:0]  floating_bus;
  logic [47:0] now_cycle;
  logic [31:0] tick_cycles;
  logic [1:0]  stick;
  logic        axis_is_y;
  logic [7:0]  position;
  logic [1:0]  button;
  logic        pressed;

  modport source (
    output valid, mode, io_offset, floating_bus, now_cycle, tick_cycles,
           stick, axis_is_y, position, button, pressed,
    input  ready
  );
  modport sink (
    input  valid, mode, io_offset, floating_bus, now_cycle, tick_cycles,
           stick, axis_is_y, position, button, pressed,
    output ready
  );
endinterface

interface gpp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

FILE: hdl/gpp_buttons.sv
// Button state, hold countdowns and the button read bit.
`timescale 1ns / 1ps
module gpp_buttons (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           exec_i,
  input  gpp_pkg::item_t item_i,
  input  logic [31:0]    hold_cycles_i,
  output logic           btn_bit_o
);
  import gpp_pkg::*;

  logic [NUM_BUTTONS-1:0] down_q, down_d;
  logic [31:0]            hold_q [NUM_BUTTONS];
  logic [31:0]            hold_d [NUM_BUTTONS];
  logic [7:0]             rd_off;

  // read bit for the button addressed by the offset
  always_comb begin
    rd_off    = item_i.io_offset - OFF_BTN_LO;
    btn_bit_o = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (rd_off[1:0] == 2'(i)) begin
        btn_bit_o = down_q[i] || (hold_q[i] != '0);
      end
    end
  end

  always_comb begin
    down_d = down_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hold_d[i] = hold_q[i];
    end
    if (exec_i) begin
      unique case (item_i.mode)
        MODE_TICK: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_d[i] = (hold_q[i] > item_i.tick_cycles) ?
                        hold_q[i] - item_i.tick_cycles : '0;
          end
        end
        MODE_BUTTON: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (item_i.button == 2'(i)) begin
              if (item_i.pressed && !down_q[i]) begin
                hold_d[i] = hold_cycles_i;
              end
              down_d[i] = item_i.pressed;
            end
          end
        end
        MODE_RESET: begin
          down_d = '0;
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_d[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold_q[i] <= '0;
      end
    end else begin
      down_q <= down_d;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold_q[i] <= hold_d[i];
      end
    end
  end

endmodule

FILE: hdl/gpp_paddle.sv
// Paddle positions, trigger time and the paddle timer compare.
`timescale 1ns / 1ps
module gpp_paddle (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           exec_i,
  input  gpp_pkg::item_t item_i,
  input  logic [7:0]     scale_i,
  input  logic [7:0]     offset_i,
  output logic           pdl_bit_o
);
  import gpp_pkg::*;

  logic [47:0] trig_q, trig_d;
  logic [7:0]  axis_q [NUM_AXES];
  logic [7:0]  axis_d [NUM_AXES];
  logic [47:0] elapsed;
  logic [15:0] prod;
  logic [16:0] limit;

  // elapsed time wraps modulo 2^48; limit fits in 17 bits
  always_comb begin
    elapsed   = item_i.now_cycle - trig_q;
    prod      = axis_q[item_i.io_offset[1:0]] * scale_i;
    limit     = {1'b0, prod} + {9'd0, offset_i};
    pdl_bit_o = (elapsed[47:17] == '0) && (elapsed[16:0] < limit);
  end

  always_comb begin
    trig_d = trig_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      axis_d[i] = axis_q[i];
    end
    if (exec_i) begin
      unique case (item_i.mode)
        MODE_READ: begin
          if (item_i.io_offset == OFF_TRIGGER) begin
            trig_d = item_i.now_cycle;
          end
        end
        MODE_AXIS: begin
          if (!item_i.stick[1]) begin
            axis_d[{item_i.stick[0], item_i.axis_is_y}] = item_i.position;
          end
        end
        MODE_RESET: begin
          trig_d = '0;
          for (int i = 0; i < NUM_AXES; i++) begin
            axis_d[i] = AXIS_RESET;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_q[i] <= AXIS_RESET;
      end
    end else begin
      trig_q <= trig_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_q[i] <= axis_d[i];
      end
    end
  end

endmodule

FILE: hdl/paddle_button_game_port.sv
// Top level: game-port paddle timer and buttons with request/result channels.
// Throughput: one request per cycle unless the result side stalls; the
//   input register, one pass of compare and counter logic, and the result
//   register form the only path.
// Reset (rst_ni low, asynchronous): channels empty, config registers at their
//   defaults, axes at 127, trigger time, button flags and countdowns at zero.
`timescale 1ns / 1ps
module paddle_button_game_port (
  input  logic              clk_i,
  input  logic              rst_ni,
  gpp_item_if.sink          in_i,
  gpp_result_if.source      out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import gpp_pkg::*;

  // config registers
  logic [31:0] hold_cfg_q;
  logic [7:0]  scale_cfg_q;
  logic [7:0]  offset_cfg_q;

  // input register
  item_t       s1_q, in_item;
  logic        s1_valid_q;

  // result register
  logic        out_valid_q;
  logic [7:0]  out_data_q, rd_data;

  logic        exec;
  logic        btn_bit, pdl_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cfg_q   <= HOLD_RESET;
      scale_cfg_q  <= SCALE_RESET;
      offset_cfg_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOLD:   hold_cfg_q   <= cfg_data_i;
        CFG_SCALE:  scale_cfg_q  <= cfg_data_i[7:0];
        CFG_OFFSET: offset_cfg_q <= cfg_data_i[7:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // The item in s1 executes once the result register can take its byte;
  // state updates and the result land on the same edge, so the next
  // request sees the updated state.
  assign exec     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || exec;

  always_comb begin
    in_item.mode         = in_i.mode;
    in_item.io_offset    = in_i.io_offset;
    in_item.floating_bus = in_i.floating_bus;
    in_item.now_cycle    = in_i.now_cycle;
    in_item.tick_cycles  = in_i.tick_cycles;
    in_item.stick        = in_i.stick;
    in_item.axis_is_y    = in_i.axis_is_y;
    in_item.position     = in_i.position;
    in_item.button       = in_i.button;
    in_item.pressed      = in_i.pressed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_item;
    end
  end

  gpp_buttons u_buttons (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .exec_i        (exec),
    .item_i        (s1_q),
    .hold_cycles_i (hold_cfg_q),
    .btn_bit_o     (btn_bit)
  );

  gpp_paddle u_paddle (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_i    (exec),
    .item_i    (s1_q),
    .scale_i   (scale_cfg_q),
    .offset_i  (offset_cfg_q),
    .pdl_bit_o (pdl_bit)
  );

  // Read byte: bit 7 from button or paddle when the offset selects one,
  // otherwise the whole floating-bus byte. Non-read modes return zero.
  always_comb begin
    rd_data = '0;
    if (s1_q.mode == MODE_READ) begin
      if (s1_q.io_offset >= OFF_BTN_LO && s1_q.io_offset <= OFF_BTN_HI) begin
        rd_data = {btn_bit, s1_q.floating_bus[6:0]};
      end else if (s1_q.io_offset >= OFF_PDL_LO && s1_q.io_offset <= OFF_PDL_HI) begin
        rd_data = {pdl_bit, s1_q.floating_bus[6:0]};
      end else begin
        rd_data = s1_q.floating_bus;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= rd_data;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;

  // a held request waits in s1 while the result side stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |=> s1_valid_q)
    else $error("request dropped from input register during stall");

  // every executed request produces a result
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("executed request produced no result");

  // only bus reads return nonzero data
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (s1_q.mode != MODE_READ) |=> out_data_q == '0)
    else $error("non-read request returned nonzero data");

endmodule

FILE: tb/gpp_shadow_pkg.sv
// Shadow copy of the game-port state that predicts and checks every read byte.
`timescale 1ns / 1ps
package gpp_shadow_pkg;
  import gpp_pkg::*;

  // Mode codes with no function; the block must answer them with zero.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  class paddle_button_shadow;
    logic [31:0] hold_cfg;
    logic [7:0]  scale_cfg;
    logic [7:0]  offset_cfg;
    logic [47:0] trig;
    logic [7:0]  axis_pos[NUM_AXES];
    bit          btn_down[NUM_BUTTONS];
    logic [31:0] hold_left[NUM_BUTTONS];
    logic [7:0]  expected_bytes[$];
    int unsigned results_seen;
    int unsigned errors;

    function new();
      hold_cfg     = HOLD_RESET;
      scale_cfg    = SCALE_RESET;
      offset_cfg   = OFFSET_RESET;
      results_seen = 0;
      errors       = 0;
      clear_pads();
    endfunction

    // Reset item and power-up: registers are left alone.
    function void clear_pads();
      trig = '0;
      for (int i = 0; i < NUM_AXES; i++) axis_pos[i] = AXIS_RESET;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_down[i]  = 1'b0;
        hold_left[i] = '0;
      end
    endfunction

    function void set_register(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_HOLD:   hold_cfg   = value;
        CFG_SCALE:  scale_cfg  = value[7:0];
        CFG_OFFSET: offset_cfg = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [47:0] pad_limit(int unsigned a);
      return 48'(axis_pos[a]) * 48'(scale_cfg) + 48'(offset_cfg);
    endfunction

    function int unsigned bytes_waiting();
      return expected_bytes.size();
    endfunction

    function void note_request(item_t it);
      logic [7:0]  data;
      logic [47:0] elapsed;
      int unsigned b;
      data = 8'h00;
      case (it.mode)
        MODE_READ: begin
          data = it.floating_bus;
          if (it.io_offset >= OFF_BTN_LO && it.io_offset <= OFF_BTN_HI) begin
            b = it.io_offset - OFF_BTN_LO;
            data = {btn_down[b] || hold_left[b] != '0, it.floating_bus[6:0]};
          end else if (it.io_offset >= OFF_PDL_LO && it.io_offset <= OFF_PDL_HI) begin
            elapsed = it.now_cycle - trig;
            data = {elapsed < pad_limit(it.io_offset[1:0]), it.floating_bus[6:0]};
          end else if (it.io_offset == OFF_TRIGGER) begin
            trig = it.now_cycle;
          end
        end
        MODE_TICK: begin
          for (int i = 0; i < NUM_BUTTONS; i++)
            hold_left[i] = (hold_left[i] > it.tick_cycles) ? hold_left[i] - it.tick_cycles : '0;
        end
        MODE_AXIS: begin
          if (it.stick < NUM_AXES / 2) axis_pos[{it.stick[0], it.axis_is_y}] = it.position;
        end
        MODE_BUTTON: begin
          if (it.button < NUM_BUTTONS) begin
            if (it.pressed && !btn_down[it.button]) hold_left[it.button] = hold_cfg;
            btn_down[it.button] = it.pressed;
          end
        end
        MODE_RESET: clear_pads();
        default: ;
      endcase
      expected_bytes.push_back(data);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] got);
      logic [7:0] want;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("result %0d read_data=%02h with no request pending",
                         results_seen, got));
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want)
        report($sformatf("result %0d read_data=%02h, want %02h", results_seen, got, want));
    endtask

    task flag_leftovers();
      if (expected_bytes.size() != 0)
        report($sformatf("%0d results never arrived", expected_bytes.size()));
    endtask
  endclass

endpackage

FILE: tb/paddle_button_game_port_test.sv
// Testbench top: random and directed requests against a shadow of the game port.
`timescale 1ns / 1ps
module paddle_button_game_port_test;
  import gpp_pkg::*;
  import gpp_shadow_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int PRESSURE_PHASE  = 4;
  // Result side hold-off for the pressure phase; the block holds only a
  // couple of requests, so the request side backs up well before this ends.
  localparam int LONG_STALL      = 400;
  // Quiet stretch after the results drain, to cover any tail.
  localparam int SETTLE_CYCLES   = 6;
  // Longest legal quiet stretch is the long stall above; the limit sits above it.
  localparam int WATCHDOG_LIMIT  = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  gpp_item_if   req_if ();
  gpp_result_if res_if ();

  paddle_button_game_port dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  paddle_button_shadow shadow = new();

  // calm: no idling on either side for the current phase.
  // stall_request: asks the result side for one long hold-off.
  bit calm          = 1'b0;
  bit stall_request = 1'b0;
  int quiet_cycles  = 0;

  // Gap lengths: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Every field but the mode random so that bits the mode does not use still toggle.
  function automatic item_t noise_request();
    item_t       it;
    logic [31:0] r0, r1, r2, r3;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    r3 = $urandom;
    it.mode         = MODE_READ;
    it.io_offset    = r0[7:0];
    it.floating_bus = r0[15:8];
    it.now_cycle    = {r1[15:0], r2};
    it.tick_cycles  = r3;
    it.stick        = r0[17:16];
    it.axis_is_y    = r0[18];
    it.position     = r0[26:19];
    it.button       = r0[28:27];
    it.pressed      = r0[29];
    return it;
  endfunction

  // Random request shaped around the shadow state: paddle reads land near
  // the timer limit, ticks near the remaining hold count, and triggers
  // sometimes sit close to the top of the 48-bit counter so reads wrap.
  function automatic item_t random_request();
    item_t       it;
    int unsigned pick, a, b;
    logic [47:0] lim;
    it   = noise_request();
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      a            = $urandom_range(0, NUM_AXES - 1);
      it.io_offset = OFF_PDL_LO + 8'(a);
      lim          = shadow.pad_limit(a);
      case ($urandom_range(0, 3))
        0: it.now_cycle = shadow.trig + lim + 48'($urandom_range(0, 6)) - 48'd3;
        1: it.now_cycle = shadow.trig + 48'($urandom_range(0, 70000));
        2: it.now_cycle = shadow.trig + 48'($urandom_range(0, 3));
        default: ;
      endcase
    end else if (pick < 42) begin
      it.io_offset = OFF_TRIGGER;
      case ($urandom_range(0, 2))
        0: it.now_cycle = '1 - 48'($urandom_range(0, 4000));
        1: it.now_cycle = shadow.trig + 48'($urandom_range(0, 100000));
        default: ;
      endcase
    end else if (pick < 57) begin
      it.io_offset = OFF_BTN_LO + 8'($urandom_range(0, NUM_BUTTONS - 1));
    end else if (pick < 67) begin
      it.mode = MODE_TICK;
      b       = $urandom_range(0, NUM_BUTTONS - 1);
      case ($urandom_range(0, 2))
        0: it.tick_cycles = shadow.hold_left[b] + 32'($urandom_range(0, 2)) - 32'd1;
        1: it.tick_cycles = 32'($urandom_range(0, 50));
        default: ;
      endcase
    end else if (pick < 79) begin
      it.mode = MODE_BUTTON;
    end else if (pick < 89) begin
      it.mode = MODE_AXIS;
    end else if (pick < 95) begin
      it.mode = MODE_READ;
    end else if (pick < 97) begin
      it.mode = MODE_RESET;
    end else begin
      it.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end
    return it;
  endfunction

  // Offer one request and hold it until accepted. valid is lowered only
  // when a gap follows, so back-to-back requests never see a 0/1 pair of
  // assignments in one time step.
  task automatic send_request(item_t it);
    int unsigned gap;
    req_if.valid        <= 1'b1;
    req_if.mode         <= it.mode;
    req_if.io_offset    <= it.io_offset;
    req_if.floating_bus <= it.floating_bus;
    req_if.now_cycle    <= it.now_cycle;
    req_if.tick_cycles  <= it.tick_cycles;
    req_if.stick        <= it.stick;
    req_if.axis_is_y    <= it.axis_is_y;
    req_if.position     <= it.position;
    req_if.button       <= it.button;
    req_if.pressed      <= it.pressed;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    shadow.note_request(it);
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_read(logic [7:0] off, logic [7:0] fb, logic [47:0] now);
    item_t it;
    it              = noise_request();
    it.io_offset    = off;
    it.floating_bus = fb;
    it.now_cycle    = now;
    send_request(it);
  endtask

  task automatic send_tick(logic [31:0] cycles);
    item_t it;
    it             = noise_request();
    it.mode        = MODE_TICK;
    it.tick_cycles = cycles;
    send_request(it);
  endtask

  task automatic send_axis(logic [1:0] stick, logic is_y, logic [7:0] pos);
    item_t it;
    it           = noise_request();
    it.mode      = MODE_AXIS;
    it.stick     = stick;
    it.axis_is_y = is_y;
    it.position  = pos;
    send_request(it);
  endtask

  task automatic send_button(logic [1:0] btn, logic down);
    item_t it;
    it         = noise_request();
    it.mode    = MODE_BUTTON;
    it.button  = btn;
    it.pressed = down;
    send_request(it);
  endtask

  task automatic send_mode(logic [2:0] m);
    item_t it;
    it      = noise_request();
    it.mode = m;
    send_request(it);
  endtask

  // Sender pause: drop valid and wait for every pending result.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (shadow.bytes_waiting() != 0);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    shadow.set_register(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: check at each accepting edge, then pick the next ready.
  initial begin : result_sink
    int unsigned stall;
    int unsigned g;
    stall        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        shadow.check_result(res_if.read_data);
      if (stall_request) begin
        stall_request = 1'b0;
        stall         = LONG_STALL;
      end
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall = g - 1;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run after too long with no handshake on either side.
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("paddle_button_game_port test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] hold;
    logic [7:0]  scale, offs;
    logic [31:0] r, r2;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_READ;
    req_if.io_offset    = '0;
    req_if.floating_bus = '0;
    req_if.now_cycle    = '0;
    req_if.tick_cycles  = '0;
    req_if.stick        = '0;
    req_if.axis_is_y    = 1'b0;
    req_if.position     = '0;
    req_if.button       = '0;
    req_if.pressed      = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_HOLD;
    cfg_data_i          = '0;
    rst_ni              = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings: axes at 127, scale 11 and offset
    // 10 set the paddle limit, trigger time zero.
    send_read(OFF_BTN_LO, 8'hFF, 48'd0);            // button up, no hold
    send_read(OFF_PDL_LO, 8'h00, 48'd0);            // zero elapsed
    send_read(OFF_PDL_HI, 8'h7F, 48'd1406);         // last cycle inside
    send_read(OFF_PDL_LO + 8'd1, 8'hFF, 48'd1407);  // first cycle outside
    send_read(OFF_TRIGGER, 8'hA5, '1);              // trigger at counter top
    send_read(OFF_PDL_LO + 8'd2, 8'h00, 48'd5);     // elapsed wraps to 6
    send_read(8'h00, 8'hFF, '1);                    // unmapped offset
    send_axis(2'd0, 1'b0, 8'd0);                    // limit is the offset alone
    send_axis(2'd1, 1'b1, 8'd255);
    send_axis(2'd2, 1'b0, 8'd9);                    // sticks 2 and 3 ignored
    send_axis(2'd3, 1'b1, 8'd9);
    send_read(OFF_TRIGGER, 8'h3C, 48'd1000);
    send_read(OFF_PDL_LO, 8'h01, 48'd1009);
    send_read(OFF_PDL_LO, 8'h01, 48'd1010);
    send_read(OFF_PDL_HI, 8'h55, 48'd3814);         // 255*11+10 - 1
    send_button(2'd1, 1'b1);
    send_tick(32'd10000);
    send_button(2'd1, 1'b1);                        // already down: no reload
    send_button(2'd1, 1'b0);
    send_read(OFF_BTN_LO + 8'd1, 8'h00, 48'd0);     // hold still running
    send_tick(32'd230);
    send_read(OFF_BTN_LO + 8'd1, 8'h00, 48'd0);     // hold just ran out
    send_button(2'd3, 1'b1);                        // no button 3
    send_tick('1);                                  // saturates at zero
    send_mode(MODE_RESET);
    send_mode(MODE_SPARE_FIRST);

    // Random phases. Phase 0 keeps the reset settings, phase 1 puts every
    // register at zero and phase 2 at its maximum; the rest are random.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk_i);
        r  = $urandom;
        r2 = $urandom;
        case (p)
          1: begin
            hold  = '0;
            scale = '0;
            offs  = '0;
          end
          2: begin
            hold  = '1;
            scale = '1;
            offs  = '1;
          end
          default: begin
            hold  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 300);
            scale = r[7:0];
            offs  = r[15:8];
          end
        endcase
        write_register(CFG_HOLD, hold);
        write_register(CFG_SCALE, {r2[31:8], scale});
        write_register(CFG_OFFSET, {r2[23:0], offs});
      end
      calm = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      // Pressure: results held back while requests keep coming.
      if (p == PRESSURE_PHASE) stall_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(random_request());
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    shadow.flag_leftovers();
    if (shadow.errors == 0) begin
      $display("paddle_button_game_port test passed");
    end else begin
      $display("paddle_button_game_port test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gpp_pkg.sv
hdl/gpp_if.sv
hdl/gpp_buttons.sv
hdl/gpp_paddle.sv
hdl/paddle_button_game_port.sv
tb/gpp_shadow_pkg.sv
tb/paddle_button_game_port_test.sv
